/* hw/rtl/exvr_pkg.sv */
// ----------------------------------------------------------------------------
// exvr_pkg
// Shared types, register indexes and the round/saturate helper for the
// Euler XYZ vertex rotator.
// ----------------------------------------------------------------------------
package exvr_pkg;

  localparam int CoordW = 16;
  localparam int FracBits = 14;
  localparam int ProdW = 2 * CoordW;
  localparam int SumW = ProdW + 1;
  localparam int CfgAddrW = 3;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [SumW-1:0] sum_t;

  typedef struct packed {
    logic signed [CoordW-1:0] in_x;
    logic signed [CoordW-1:0] in_y;
    logic signed [CoordW-1:0] in_z;
  } in_vertex_t;

  typedef struct packed {
    logic signed [CoordW-1:0] out_x;
    logic signed [CoordW-1:0] out_y;
    logic signed [CoordW-1:0] out_z;
  } out_vertex_t;

  typedef enum logic [CfgAddrW-1:0] {
    REG_COS_ROLL  = 3'd0,
    REG_SIN_ROLL  = 3'd1,
    REG_COS_PITCH = 3'd2,
    REG_SIN_PITCH = 3'd3,
    REG_COS_YAW   = 3'd4,
    REG_SIN_YAW   = 3'd5
  } cfg_reg_t;

  localparam coord_t CosReset = 16'sd16384;
  localparam coord_t SinReset = 16'sd0;
  localparam coord_t CoordMax = 16'sh7fff;
  localparam coord_t CoordMin = 16'sh8000;

  // floor((sum + 2^13) / 2^14), clamped to 16 bits
  function automatic coord_t round_sat(input sum_t sum);
    logic signed [SumW:0] biased;
    logic signed [SumW-FracBits:0] q;
    biased = (SumW+1)'(sum) + (SumW+1)'(signed'(1 <<< (FracBits - 1)));
    q = biased[SumW:FracBits];
    if (q > (SumW-FracBits+1)'(CoordMax)) begin
      return CoordMax;
    end else if (q < (SumW-FracBits+1)'(CoordMin)) begin
      return CoordMin;
    end
    return q[CoordW-1:0];
  endfunction

endpackage

/* hw/rtl/euler_xyz_vertex_rotator.sv */
// ----------------------------------------------------------------------------
// euler_xyz_vertex_rotator
// Rotates a Q2.13 vertex about X, then Y, then Z using Q1.14 cos/sin regs.
// ----------------------------------------------------------------------------
// Pipeline: roll A, roll B, pitch A, pitch B, yaw A and yaw B registers lie
//   between an accepted input and its result; yaw B is the output register.
// Throughput: one item per cycle; the whole six-register pipeline advances
//   together whenever the output register is empty or being taken.
// Reset (rst_n low, synchronous): pipeline valid bits clear, cos regs load
//   1.0 (16384) and sin regs load 0, i.e. identity rotation.
module euler_xyz_vertex_rotator (
  input  logic                          clk,
  input  logic                          rst_n,
  // vertex input
  input  logic                          in_valid,
  output logic                          in_ready,
  input  exvr_pkg::in_vertex_t          in_data,
  // rotated vertex output
  output logic                          out_valid,
  input  logic                          out_ready,
  output exvr_pkg::out_vertex_t         out_data,
  // register writes
  input  logic                          cfg_we,
  input  logic [exvr_pkg::CfgAddrW-1:0] cfg_addr,
  input  logic [exvr_pkg::CoordW-1:0]   cfg_wdata
);
  import exvr_pkg::*;

  // Q1.14 coefs. User must write only while the pipeline is idle; unchecked.
  coord_t cos_roll_r, sin_roll_r;
  coord_t cos_pitch_r, sin_pitch_r;
  coord_t cos_yaw_r, sin_yaw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_roll_r  <= CosReset;
      sin_roll_r  <= SinReset;
      cos_pitch_r <= CosReset;
      sin_pitch_r <= SinReset;
      cos_yaw_r   <= CosReset;
      sin_yaw_r   <= SinReset;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_COS_ROLL:  cos_roll_r  <= cfg_wdata;
        REG_SIN_ROLL:  sin_roll_r  <= cfg_wdata;
        REG_COS_PITCH: cos_pitch_r <= cfg_wdata;
        REG_SIN_PITCH: sin_pitch_r <= cfg_wdata;
        REG_COS_YAW:   cos_yaw_r   <= cfg_wdata;
        REG_SIN_YAW:   sin_yaw_r   <= cfg_wdata;
        default: ; // unused indexes are dropped
      endcase
    end
  end

  // Global advance: the last stage is the output register, so the pipe
  // moves whenever that register is free or its item leaves this cycle.
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Roll: y1 = y*c - z*s, z1 = y*s + z*c (x rides along)
  logic   roll_vld;
  coord_t y1, z1, x0;

  exvr_rot_stage u_roll (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (in_valid),
    .in_u    (in_data.in_y),
    .in_v    (in_data.in_z),
    .in_w    (in_data.in_x),
    .c       (cos_roll_r),
    .s       (sin_roll_r),
    .out_vld (roll_vld),
    .out_u   (y1),
    .out_v   (z1),
    .out_w   (x0)
  );

  // Pitch: with u = z1, v = x: z2 = z1*c - x*s, x1 = z1*s + x*c
  logic   pitch_vld;
  coord_t z2, x1, y1_d;

  exvr_rot_stage u_pitch (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (roll_vld),
    .in_u    (z1),
    .in_v    (x0),
    .in_w    (y1),
    .c       (cos_pitch_r),
    .s       (sin_pitch_r),
    .out_vld (pitch_vld),
    .out_u   (z2),
    .out_v   (x1),
    .out_w   (y1_d)
  );

  // Yaw: x2 = x1*c - y1*s, y2 = x1*s + y1*c; its stage B is the output reg
  coord_t x2, y2, z2_d;

  exvr_rot_stage u_yaw (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (pitch_vld),
    .in_u    (x1),
    .in_v    (y1_d),
    .in_w    (z2),
    .c       (cos_yaw_r),
    .s       (sin_yaw_r),
    .out_vld (out_valid),
    .out_u   (x2),
    .out_v   (y2),
    .out_w   (z2_d)
  );

  assign out_data.out_x = x2;
  assign out_data.out_y = y2;
  assign out_data.out_z = z2_d;

endmodule

/* hw/rtl/exvr_rot_stage.sv */
// ----------------------------------------------------------------------------
// exvr_rot_stage
// One plane rotation, two register stages: products, then sum/round/sat.
// u' = u*c - v*s, v' = u*s + v*c; w passes through.
// ----------------------------------------------------------------------------
module exvr_rot_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_vld,
  input  exvr_pkg::coord_t in_u,
  input  exvr_pkg::coord_t in_v,
  input  exvr_pkg::coord_t in_w,
  input  exvr_pkg::coord_t c,
  input  exvr_pkg::coord_t s,
  output logic            out_vld,
  output exvr_pkg::coord_t out_u,
  output exvr_pkg::coord_t out_v,
  output exvr_pkg::coord_t out_w
);
  import exvr_pkg::*;

  logic   vld1_r, vld2_r;
  prod_t  uc_r, vs_r, us_r, vc_r;
  coord_t w1_r, u2_r, v2_r, w2_r;
  coord_t u_nxt, v_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
    end
  end

  // stage A: four products
  always_ff @(posedge clk) begin
    if (en) begin
      uc_r <= ProdW'(in_u) * ProdW'(c);
      vs_r <= ProdW'(in_v) * ProdW'(s);
      us_r <= ProdW'(in_u) * ProdW'(s);
      vc_r <= ProdW'(in_v) * ProdW'(c);
      w1_r <= in_w;
    end
  end

  always_comb begin
    u_nxt = round_sat(SumW'(uc_r) - SumW'(vs_r));
    v_nxt = round_sat(SumW'(us_r) + SumW'(vc_r));
  end

  // stage B: rounded, saturated pair
  always_ff @(posedge clk) begin
    if (en) begin
      u2_r <= u_nxt;
      v2_r <= v_nxt;
      w2_r <= w1_r;
    end
  end

  assign out_vld = vld2_r;
  assign out_u   = u2_r;
  assign out_v   = v2_r;
  assign out_w   = w2_r;

endmodule

/* hw/rtl/exvr_checker.sv */
// ----------------------------------------------------------------------------
// exvr_checker
// Port-level checks for the vertex rotator, bound to the top level.
// ----------------------------------------------------------------------------
module exvr_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input exvr_pkg::in_vertex_t          in_data,
  input logic                          out_valid,
  input logic                          out_ready,
  input exvr_pkg::out_vertex_t         out_data,
  input logic                          cfg_we,
  input logic [exvr_pkg::CfgAddrW-1:0] cfg_addr,
  input logic [exvr_pkg::CoordW-1:0]   cfg_wdata
);
  import exvr_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // an empty output stage never back-pressures the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // the origin maps to the origin under any rotation while the pipe keeps flowing
  a_origin: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data == '0)
      ##1 in_ready ##1 in_ready ##1 in_ready ##1 in_ready ##1 in_ready
      |=> out_valid && out_data == '0)
    else $error("origin not preserved");

endmodule

bind euler_xyz_vertex_rotator exvr_checker u_exvr_checker (.*);

/* test/tb_euler_xyz_vertex_rotator.sv */
// ----------------------------------------------------------------------------
// tb_euler_xyz_vertex_rotator
// Self-checking bench for the XYZ Euler rotator. A scoreboard class rotates
// every accepted vertex in software (roll, pitch, yaw, each stage rounded and
// clamped) and compares each output item field by field in order. Stimulus is
// a few directed vertices under identity, rounding, saturating and
// out-of-range coefficient sets, then random vertices under a series of
// register settings, with random valid/ready gaps on both sides.
// ----------------------------------------------------------------------------
module tb_euler_xyz_vertex_rotator;
  timeunit 1ns;
  timeprecision 1ps;

  import exvr_pkg::*;

  localparam int StallLimit = 2000;   // cycles with no handshake on either side
  localparam int DrainCycles = 20;    // idle wait that lets any stray item drain out
  localparam int NumPhases = 8;
  localparam int ItemsPerPhase = 212;
  localparam int MaxGap = 18;
  localparam int NumAddrs = 1 << CfgAddrW;

  // --------------------------------------------------------------------------
  // Scoreboard: holds its own copy of the six coefficients and a queue of
  // rotated vertices waiting to come out of the block.
  // --------------------------------------------------------------------------
  class rotation_scoreboard;
    coord_t cos_roll_q, sin_roll_q, cos_pitch_q, sin_pitch_q, cos_yaw_q, sin_yaw_q;
    out_vertex_t rotated_q[$];
    int errors;

    function new();
      cos_roll_q = CosReset;
      sin_roll_q = SinReset;
      cos_pitch_q = CosReset;
      sin_pitch_q = SinReset;
      cos_yaw_q = CosReset;
      sin_yaw_q = SinReset;
      errors = 0;
    endfunction

    // writes to unused indexes leave everything as it was
    function void set_reg(logic [CfgAddrW-1:0] addr, coord_t val);
      case (addr)
        REG_COS_ROLL:  cos_roll_q = val;
        REG_SIN_ROLL:  sin_roll_q = val;
        REG_COS_PITCH: cos_pitch_q = val;
        REG_SIN_PITCH: sin_pitch_q = val;
        REG_COS_YAW:   cos_yaw_q = val;
        REG_SIN_YAW:   sin_yaw_q = val;
        default: ;
      endcase
    endfunction

    // floor((acc + 2^13) / 2^14), then clamp into 16 bits
    function coord_t round_clamp(longint acc);
      longint q;
      q = (acc + (longint'(1) <<< (FracBits - 1))) >>> FracBits;
      if (q > longint'(CoordMax)) return CoordMax;
      if (q < longint'(CoordMin)) return CoordMin;
      return coord_t'(q);
    endfunction

    // a*b +/- c*d, exact products
    function coord_t mul_pair(coord_t a, coord_t b, coord_t c, coord_t d, bit sub);
      longint p;
      longint r;
      p = longint'(a) * longint'(b);
      r = longint'(c) * longint'(d);
      return round_clamp(sub ? p - r : p + r);
    endfunction

    function void note_input(in_vertex_t v);
      coord_t y1, z1, x1, z2;
      out_vertex_t res;
      // roll about X
      y1 = mul_pair(v.in_y, cos_roll_q, v.in_z, sin_roll_q, 1'b1);
      z1 = mul_pair(v.in_y, sin_roll_q, v.in_z, cos_roll_q, 1'b0);
      // pitch about Y
      x1 = mul_pair(v.in_x, cos_pitch_q, z1, sin_pitch_q, 1'b0);
      z2 = mul_pair(z1, cos_pitch_q, v.in_x, sin_pitch_q, 1'b1);
      // yaw about Z
      res.out_x = mul_pair(x1, cos_yaw_q, y1, sin_yaw_q, 1'b1);
      res.out_y = mul_pair(x1, sin_yaw_q, y1, cos_yaw_q, 1'b0);
      res.out_z = z2;
      rotated_q.push_back(res);
    endfunction

    function int pending();
      return rotated_q.size();
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(out_vertex_t got);
      out_vertex_t want;
      if (rotated_q.size() == 0) begin
        report($sformatf("unexpected item x=%0d y=%0d z=%0d",
                         got.out_x, got.out_y, got.out_z));
        return;
      end
      want = rotated_q.pop_front();
      if (got.out_x !== want.out_x) begin
        report($sformatf("out_x got %0d want %0d", got.out_x, want.out_x));
      end
      if (got.out_y !== want.out_y) begin
        report($sformatf("out_y got %0d want %0d", got.out_y, want.out_y));
      end
      if (got.out_z !== want.out_z) begin
        report($sformatf("out_z got %0d want %0d", got.out_z, want.out_z));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_vertex_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_vertex_t out_data;
  logic cfg_we = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr = '0;
  logic [CoordW-1:0] cfg_wdata = '0;

  euler_xyz_vertex_rotator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  rotation_scoreboard sb = new();

  // per-phase switches: when set, that side never idles
  bit in_burst = 1'b0;
  bit out_burst = 1'b0;

  // --------------------------------------------------------------------------
  // Watchdog: any accepted item on either channel resets the count
  // --------------------------------------------------------------------------
  int stall_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Output side: random ready gaps, each taken item goes to the scoreboard.
  // Sampling right after the edge sees the values the DUT presented at it;
  // an unknown valid before the first reset edge is not an item.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int gap;
    forever begin
      gap = out_burst ? 0 : $urandom_range(0, MaxGap);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_result(out_data);
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Holds valid and data until accepted. valid only drops when a gap is
  // drawn, so back-to-back items never see a low/high pair in one step.
  task automatic send_vertex(input coord_t x, input coord_t y, input coord_t z);
    int gap;
    in_vertex_t v;
    v = '{x, y, z};
    gap = in_burst ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= v;
    do @(posedge clk); while (!in_ready);
    sb.note_input(v);
  endtask

  // Each result comes from exactly one item, so an empty queue means the
  // pipeline is empty too.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] addr, input coord_t val);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(addr, val);
  endtask

  task automatic set_rotation(input coord_t cr, input coord_t sr, input coord_t cp,
                              input coord_t sp, input coord_t cy, input coord_t sy);
    write_reg(REG_COS_ROLL, cr);
    write_reg(REG_SIN_ROLL, sr);
    write_reg(REG_COS_PITCH, cp);
    write_reg(REG_SIN_PITCH, sp);
    write_reg(REG_COS_YAW, cy);
    write_reg(REG_SIN_YAW, sy);
    cfg_we <= 1'b0;
  endtask

  // mostly full-width random, sometimes a corner value
  function automatic coord_t rand_coord();
    coord_t corners[7] = '{CoordMin, CoordMax, 16'sd0, 16'sd1, -16'sd1,
                           16'sd16384, -16'sd16384};
    if ($urandom_range(0, 7) == 0) begin
      return corners[$urandom_range(0, 6)];
    end
    return coord_t'($urandom);
  endfunction

  // coefficient styles: in-range, any 16-bit pattern, or a corner value
  function automatic coord_t rand_coef(int style);
    coord_t corners[6] = '{-16'sd16384, 16'sd16384, 16'sd0, CoordMin, CoordMax,
                           16'sd8192};
    case (style)
      0: return coord_t'($urandom_range(0, 32768)) - 16'sd16384;
      1: return coord_t'($urandom);
      default: return corners[$urandom_range(0, 5)];
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    int a;
    int style;
    coord_t c[6];

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity rotation out of reset: output must equal input
    send_vertex(16'sd0, 16'sd0, 16'sd0);
    send_vertex(CoordMax, CoordMax, CoordMax);
    send_vertex(CoordMin, CoordMin, CoordMin);
    send_vertex(-16'sd1, -16'sd1, -16'sd1);
    send_vertex(16'sd1, -16'sd1, CoordMax);
    send_vertex(CoordMin, CoordMax, 16'sd0);
    wait_idle();

    // half-scale coefficients: odd coordinates land on the rounding midpoint;
    // writes to the unused indexes must change nothing
    set_rotation(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192);
    @(posedge clk);
    for (a = int'(REG_SIN_YAW) + 1; a < NumAddrs; a++) begin
      write_reg(a[CfgAddrW-1:0], CoordMin);
    end
    cfg_we <= 1'b0;
    send_vertex(16'sd1, 16'sd1, 16'sd1);
    send_vertex(-16'sd1, -16'sd1, -16'sd1);
    send_vertex(16'sd3, -16'sd3, 16'sd1);
    send_vertex(CoordMax, CoordMin, 16'sd1);
    wait_idle();

    // cos = sin = 1.0: sums overflow, every stage saturates
    set_rotation(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
    send_vertex(CoordMax, CoordMax, CoordMax);
    send_vertex(CoordMin, CoordMin, CoordMin);
    send_vertex(CoordMax, CoordMin, CoordMax);
    send_vertex(16'sd16384, 16'sd16384, 16'sd16384);
    wait_idle();

    // coefficients outside +-1.0, both 16-bit extremes
    set_rotation(CoordMin, CoordMax, CoordMin, CoordMax, CoordMin, CoordMax);
    send_vertex(CoordMax, CoordMax, CoordMax);
    send_vertex(CoordMin, CoordMin, CoordMin);
    send_vertex(CoordMin, CoordMax, -16'sd1);
    wait_idle();

    // random vertices under a new coefficient set per phase; the first
    // phase of every four runs both sides without gaps
    for (int p = 0; p < NumPhases; p++) begin
      style = p % 4;
      foreach (c[i]) begin
        c[i] = (style == 3) ? ((i % 2 == 0) ? -16'sd16384 : 16'sd16384)
                            : rand_coef(style);
      end
      set_rotation(c[0], c[1], c[2], c[3], c[4], c[5]);
      in_burst = (style == 0) || ($urandom_range(0, 3) == 0);
      out_burst = (style == 0) || ($urandom_range(0, 3) == 0);
      repeat (ItemsPerPhase) send_vertex(rand_coord(), rand_coord(), rand_coord());
      wait_idle();
    end

    // nothing left queued; give a stray late item a chance to show up
    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
